// ----- sv/ckc_pkg.sv -----
package ckc_pkg;

    // Screen geometry defaults; the top level hands these down as parameters.
    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_PIXELS_DEF = 20480;

    // Width of the raster index computation, enough for row * width + column
    // over the whole parameter range.
    localparam int unsigned IDX_W = 18;

    // Width of a stored index; the largest supported screen has 65536 pixels.
    localparam int unsigned INDEX_W = 16;

    localparam int unsigned PIXEL_W = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // A begin command sends this many bytes.
    localparam int unsigned BEGIN_LEN = 11;
    localparam int unsigned STEP_W = 4;

    // Display command bytes.
    localparam logic [7:0] OP_COLSET = 8'h2A;
    localparam logic [7:0] OP_ROWSET = 8'h2B;
    localparam logic [7:0] OP_MEMWR  = 8'h2C;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_START    = 3'd0,
        CFG_X_END      = 3'd1,
        CFG_Y_START    = 3'd2,
        CFG_Y_END      = 3'd3,
        CFG_KEY_COLOR  = 3'd4,
        CFG_WRITE_BACK = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [6:0]         win_x_start;
        logic [6:0]         win_x_end;
        logic [7:0]         win_y_start;
        logic [7:0]         win_y_end;
        logic [PIXEL_W-1:0] key_color;
        logic               write_back;
    } cfg_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        cmd_t               cmd;
        logic               on_screen;
        logic [INDEX_W-1:0] index;
        logic [PIXEL_W-1:0] pixel;
    } op_t;

    // One item handed from the store stage to the byte emitter.
    typedef struct packed {
        cmd_t               cmd;
        logic [PIXEL_W-1:0] data;
    } emit_t;

endpackage

// ----- sv/ckc_if.sv -----
interface ckc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [14:0] address;
    logic [15:0] pixel_value;

    modport source (output valid, output cmd, output address, output pixel_value,
                    input ready);
    modport sink   (input valid, input cmd, input address, input pixel_value,
                    output ready);
endinterface

interface ckc_link_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        last;
    logic [15:0] read_value;

    modport source (output valid, output out_byte, output is_data, output last,
                    output read_value, input ready);
    modport sink   (input valid, input out_byte, input is_data, input last,
                    input read_value, output ready);
endinterface

// ----- sv/color_key_sprite_compositor.sv -----
// Color-key sprite compositor for an RGB565 display link.
// Items arrive on cmd_ch (valid/ready): load a background pixel, begin a
// window, send a sprite pixel, or read a background pixel. Bytes leave on
// link_ch (valid/ready) with is_data, last and read_value; last marks the
// final byte caused by one item. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
// Throughput: a sprite pixel produces two bytes, and the output emitter
// sends one byte per cycle while the receiver is ready. A begin item
// occupies the emitter for its 11 bytes; loads pass through the store stage
// and produce nothing. An accepted item passes the queue, the store stage
// read and the emitter register before its first byte shows on link_ch.
// Reset clears the cursor, the pipeline valids and the registers to their
// defaults; the background store is not cleared and holds garbage until
// loaded. When the receiver stalls, the emitter holds its byte, the store
// stage and the two-entry queue fill, and cmd_ch.ready drops.
module color_key_sprite_compositor #(
    parameter int unsigned SCREEN_WIDTH  = ckc_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_PIXELS = ckc_pkg::SCREEN_PIXELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ckc_cmd_if.sink                            cmd_ch,
    ckc_link_if.source                         link_ch,
    input  logic                               cfg_we,
    input  logic [ckc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ckc_pkg::cfg_t   cfg_reg;
    ckc_pkg::cfg_t   cfg_next;

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    ckc_pkg::op_t    q_din;
    ckc_pkg::op_t    q_head;

    logic            emit_free;
    logic            emit_load;
    ckc_pkg::emit_t  emit_item;

    // Register file. Indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ckc_pkg::CFG_X_START:    cfg_next.win_x_start = cfg_data[6:0];
                ckc_pkg::CFG_X_END:      cfg_next.win_x_end   = cfg_data[6:0];
                ckc_pkg::CFG_Y_START:    cfg_next.win_y_start = cfg_data[7:0];
                ckc_pkg::CFG_Y_END:      cfg_next.win_y_end   = cfg_data[7:0];
                ckc_pkg::CFG_KEY_COLOR:  cfg_next.key_color   = cfg_data;
                ckc_pkg::CFG_WRITE_BACK: cfg_next.write_back  = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_x_start <= 7'd0;
            cfg_reg.win_x_end   <= 7'd127;
            cfg_reg.win_y_start <= 8'd0;
            cfg_reg.win_y_end   <= 8'd159;
            cfg_reg.key_color   <= '0;
            cfg_reg.write_back  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front owns the raster cursor and turns each item into a store
    // operation with its screen index and a flag for whether it lies on screen.
    ckc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_PIXELS (SCREEN_PIXELS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (q_push),
        .op     (q_din)
    );

    // Short queue so the front keeps taking items while the back is busy.
    ckc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    // The back reads the background store, applies the color key, writes
    // loads and write-back composites, and hands byte-producing items on.
    // All store accesses happen in item order here, so no hazard escapes.
    ckc_back #(
        .SCREEN_PIXELS (SCREEN_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (q_pop),
        .emit_free (emit_free),
        .emit_load (emit_load),
        .emit_item (emit_item)
    );

    // The emitter sends one byte per cycle from its output register while the receiver is ready.
    ckc_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .load    (emit_load),
        .item    (emit_item),
        .free    (emit_free),
        .link_ch (link_ch)
    );

endmodule

// ----- sv/ckc_front.sv -----
module ckc_front #(
    parameter int unsigned SCREEN_WIDTH  = ckc_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_PIXELS = ckc_pkg::SCREEN_PIXELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ckc_cmd_if.sink        cmd_ch,
    input  ckc_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           push,
    output ckc_pkg::op_t   op
);

    logic [6:0]                 cursor_col_reg;
    logic [6:0]                 cursor_col_next;
    logic [7:0]                 cursor_row_reg;
    logic [7:0]                 cursor_row_next;
    logic [ckc_pkg::IDX_W-1:0]  raster_idx;
    logic [ckc_pkg::IDX_W-1:0]  sel_idx;
    ckc_pkg::cmd_t              cmd;

    assign cmd_ch.ready = !q_full;
    assign push         = cmd_ch.valid && !q_full;
    assign cmd          = ckc_pkg::cmd_t'(cmd_ch.cmd);

    // Screen index of the cursor.
    assign raster_idx = ckc_pkg::IDX_W'(cursor_row_reg) * ckc_pkg::IDX_W'(SCREEN_WIDTH)
                      + ckc_pkg::IDX_W'(cursor_col_reg);

    always_comb
    begin
        if (cmd == ckc_pkg::CMD_PIXEL)
        begin
            sel_idx = raster_idx;
        end
        else
        begin
            sel_idx = ckc_pkg::IDX_W'(cmd_ch.address);
        end
        op.cmd       = cmd;
        op.on_screen = sel_idx < ckc_pkg::IDX_W'(SCREEN_PIXELS);
        op.index     = sel_idx[ckc_pkg::INDEX_W-1:0];
        op.pixel     = cmd_ch.pixel_value;
    end

    // Begin restarts the window; pixels advance, wrapping at register widths.
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (push)
        begin
            priority if (cmd == ckc_pkg::CMD_BEGIN)
            begin
                cursor_col_next = cfg.win_x_start;
                cursor_row_next = cfg.win_y_start;
            end
            else if (cmd == ckc_pkg::CMD_PIXEL)
            begin
                if (cursor_col_reg == cfg.win_x_end)
                begin
                    cursor_col_next = cfg.win_x_start;
                    if (cursor_row_reg == cfg.win_y_end)
                    begin
                        cursor_row_next = cfg.win_y_start;
                    end
                    else
                    begin
                        cursor_row_next = cursor_row_reg + 8'd1;
                    end
                end
                else
                begin
                    cursor_col_next = cursor_col_reg + 7'd1;
                end
            end
            else
            begin
                cursor_col_next = cursor_col_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

// ----- sv/ckc_queue.sv -----
module ckc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ckc_pkg::op_t  din,
    output logic          full,
    input  logic          pop,
    output ckc_pkg::op_t  dout,
    output logic          empty
);

    localparam int unsigned DEPTH = ckc_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ckc_pkg::op_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- sv/ckc_back.sv -----
module ckc_back #(
    parameter int unsigned SCREEN_PIXELS = ckc_pkg::SCREEN_PIXELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ckc_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  ckc_pkg::op_t   q_head,
    output logic           pop,
    input  logic           emit_free,
    output logic           emit_load,
    output ckc_pkg::emit_t emit_item
);

    localparam int unsigned AW = $clog2(SCREEN_PIXELS);

    logic [ckc_pkg::PIXEL_W-1:0] store_mem [SCREEN_PIXELS];

    logic                        r_valid_reg;
    logic                        r_valid_next;
    ckc_pkg::op_t                r_op_reg;
    logic [ckc_pkg::PIXEL_W-1:0] rd_data_reg;
    logic                        fwd_reg;
    logic [ckc_pkg::PIXEL_W-1:0] fwd_data_reg;

    logic                        transfer;
    logic [ckc_pkg::PIXEL_W-1:0] stored;
    logic [ckc_pkg::PIXEL_W-1:0] composite;
    logic [ckc_pkg::PIXEL_W-1:0] wdata;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic                        we;

    // Loads leave no bytes, so they retire without waiting for the emitter.
    assign transfer = r_valid_reg && (emit_free || r_op_reg.cmd == ckc_pkg::CMD_LOAD);
    assign pop      = !q_empty && (!r_valid_reg || transfer);

    assign waddr = r_op_reg.index[AW-1:0];
    assign raddr = q_head.index[AW-1:0];

    // A same-cycle write to the address the next item reads is forwarded.
    assign stored = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        if (r_op_reg.pixel == cfg.key_color)
        begin
            composite = r_op_reg.on_screen ? stored : '0;
        end
        else
        begin
            composite = r_op_reg.pixel;
        end

        we    = 1'b0;
        wdata = composite;
        unique case (r_op_reg.cmd)
            ckc_pkg::CMD_LOAD:
            begin
                we    = transfer && r_op_reg.on_screen;
                wdata = r_op_reg.pixel;
            end
            ckc_pkg::CMD_PIXEL:
            begin
                we = transfer && r_op_reg.on_screen && cfg.write_back;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase

        emit_load     = transfer && (r_op_reg.cmd != ckc_pkg::CMD_LOAD);
        emit_item.cmd = r_op_reg.cmd;
        unique case (r_op_reg.cmd)
            ckc_pkg::CMD_READ:  emit_item.data = r_op_reg.on_screen ? stored : '0;
            ckc_pkg::CMD_PIXEL: emit_item.data = composite;
            default:            emit_item.data = '0;
        endcase
    end

    always_comb
    begin
        r_valid_next = r_valid_reg;
        if (pop)
        begin
            r_valid_next = 1'b1;
        end
        else if (transfer)
        begin
            r_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (pop)
        begin
            rd_data_reg  <= store_mem[raddr];
            r_op_reg     <= q_head;
            fwd_reg      <= we && (waddr == raddr);
            fwd_data_reg <= wdata;
        end
    end

endmodule

// ----- sv/ckc_emit.sv -----
module ckc_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  ckc_pkg::cfg_t  cfg,
    input  logic           load,
    input  ckc_pkg::emit_t item,
    output logic           free,
    ckc_link_if.source     link_ch
);

    logic                         valid_reg;
    logic                         valid_next;
    ckc_pkg::emit_t               item_reg;
    logic [ckc_pkg::STEP_W-1:0]   step_reg;
    logic [ckc_pkg::STEP_W-1:0]   step_next;
    logic                         last_step;
    logic                         done;

    always_comb
    begin
        unique case (item_reg.cmd)
            ckc_pkg::CMD_BEGIN: last_step = step_reg == ckc_pkg::STEP_W'(ckc_pkg::BEGIN_LEN - 1);
            ckc_pkg::CMD_PIXEL: last_step = step_reg == ckc_pkg::STEP_W'(1);
            default:            last_step = 1'b1;
        endcase
    end

    assign done = valid_reg && link_ch.ready && last_step;
    assign free = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && link_ch.ready)
        begin
            step_next = step_reg + ckc_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign link_ch.valid = valid_reg;

    always_comb
    begin
        link_ch.out_byte   = '0;
        link_ch.is_data    = 1'b1;
        link_ch.last       = 1'b0;
        link_ch.read_value = '0;
        unique case (item_reg.cmd)
            ckc_pkg::CMD_BEGIN:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        link_ch.out_byte = ckc_pkg::OP_COLSET;
                        link_ch.is_data  = 1'b0;
                    end
                    4'd2:    link_ch.out_byte = 8'(cfg.win_x_start);
                    4'd4:    link_ch.out_byte = 8'(cfg.win_x_end);
                    4'd5:
                    begin
                        link_ch.out_byte = ckc_pkg::OP_ROWSET;
                        link_ch.is_data  = 1'b0;
                    end
                    4'd7:    link_ch.out_byte = cfg.win_y_start;
                    4'd9:    link_ch.out_byte = cfg.win_y_end;
                    4'd10:
                    begin
                        link_ch.out_byte = ckc_pkg::OP_MEMWR;
                        link_ch.is_data  = 1'b0;
                        link_ch.last     = 1'b1;
                    end
                    default: link_ch.out_byte = '0;
                endcase
            end
            ckc_pkg::CMD_PIXEL:
            begin
                if (step_reg == '0)
                begin
                    link_ch.out_byte = item_reg.data[15:8];
                end
                else
                begin
                    link_ch.out_byte = item_reg.data[7:0];
                    link_ch.last     = 1'b1;
                end
            end
            ckc_pkg::CMD_READ:
            begin
                link_ch.is_data    = 1'b0;
                link_ch.last       = 1'b1;
                link_ch.read_value = item_reg.data;
            end
            default:
            begin
                link_ch.is_data = 1'b0;
            end
        endcase
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    // Self-checking bench for the color-key sprite compositor.
    //
    // A mirror of the block lives in the class below. It holds its own copy of
    // the registers, the raster cursor and the background store, and turns
    // every accepted command item into the list of link bytes that the block
    // must send. The receiver process checks each accepted byte against the
    // oldest entry of that list. The main process drives a short directed part
    // and then a series of random phases. Each phase uses its own register
    // setting, written only while the block is idle.

    localparam int unsigned SCREEN_WIDTH    = ckc_pkg::SCREEN_WIDTH_DEF;
    localparam int unsigned SCREEN_PIXELS   = ckc_pkg::SCREEN_PIXELS_DEF;
    localparam int unsigned ADDRESS_SPAN    = 1 << 15;
    // Percentage of cycles in which each side idles when idling is allowed.
    localparam int unsigned IDLE_PCT        = 37;
    // Cycles to let pass once the last byte has come, so that a trailing load
    // has surely left the pipeline (a load passes the queue and the store stage).
    localparam int unsigned SETTLE_CYCLES   = 10;
    // Length of the one long receiver stall that fills the pipeline.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // The longest legal stretch without any handshake is the hold-off above
    // plus a few random gaps, so this leaves a wide margin.
    localparam int unsigned WATCHDOG_LIMIT  = 2000;

    // One byte on the display link, with its side fields.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic        last;
        logic [15:0] read_value;
    } link_byte_t;

    // Mirror of the compositor: it computes the link bytes that each accepted
    // item causes and holds them until the block sends them.
    class compositor_mirror;
        logic [15:0]   bg_store [SCREEN_PIXELS];
        bit            bg_written [SCREEN_PIXELS];
        int unsigned   written_addr [$];
        logic [6:0]    cursor_col;
        logic [7:0]    cursor_row;
        ckc_pkg::cfg_t regs;
        link_byte_t    pending_link_bytes [$];
        int unsigned   mismatch_count;

        function new();
            cursor_col          = 7'd0;
            cursor_row          = 8'd0;
            regs.win_x_start    = 7'd0;
            regs.win_x_end      = 7'd127;
            regs.win_y_start    = 8'd0;
            regs.win_y_end      = 8'd159;
            regs.key_color      = 16'h0000;
            regs.write_back     = 1'b0;
            mismatch_count      = 0;
        endfunction

        function void set_register(ckc_pkg::cfg_index_t idx, logic [15:0] value);
            case (idx)
                ckc_pkg::CFG_X_START:    regs.win_x_start = value[6:0];
                ckc_pkg::CFG_X_END:      regs.win_x_end   = value[6:0];
                ckc_pkg::CFG_Y_START:    regs.win_y_start = value[7:0];
                ckc_pkg::CFG_Y_END:      regs.win_y_end   = value[7:0];
                ckc_pkg::CFG_KEY_COLOR:  regs.key_color   = value;
                ckc_pkg::CFG_WRITE_BACK: regs.write_back  = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned cursor_index();
            return int'(cursor_row) * SCREEN_WIDTH + int'(cursor_col);
        endfunction

        // True when a sprite pixel of this value would pull a background entry
        // that has never been loaded.
        function bit needs_background(logic [15:0] pix);
            int unsigned idx;
            idx = cursor_index();
            return (pix == regs.key_color) && (idx < SCREEN_PIXELS) && !bg_written[idx];
        endfunction

        function void store_pixel(int unsigned idx, logic [15:0] value);
            bg_store[idx] = value;
            if (!bg_written[idx])
            begin
                bg_written[idx] = 1'b1;
                written_addr.push_back(idx);
            end
        endfunction

        function void add_byte(logic [7:0] b, logic d, logic l, logic [15:0] rv);
            link_byte_t item;
            item.out_byte   = b;
            item.is_data    = d;
            item.last       = l;
            item.read_value = rv;
            pending_link_bytes.push_back(item);
        endfunction

        function void take_item(ckc_pkg::cmd_t c, logic [14:0] addr, logic [15:0] pix);
            int unsigned idx;
            bit          on_screen;
            logic [15:0] res;
            idx       = cursor_index();
            on_screen = idx < SCREEN_PIXELS;
            case (c)
                ckc_pkg::CMD_LOAD:
                begin
                    if (addr < SCREEN_PIXELS)
                        store_pixel(32'(addr), pix);
                end
                ckc_pkg::CMD_BEGIN:
                begin
                    add_byte(ckc_pkg::OP_COLSET, 1'b0, 1'b0, 16'h0000);
                    add_byte(8'h00, 1'b1, 1'b0, 16'h0000);
                    add_byte({1'b0, regs.win_x_start}, 1'b1, 1'b0, 16'h0000);
                    add_byte(8'h00, 1'b1, 1'b0, 16'h0000);
                    add_byte({1'b0, regs.win_x_end}, 1'b1, 1'b0, 16'h0000);
                    add_byte(ckc_pkg::OP_ROWSET, 1'b0, 1'b0, 16'h0000);
                    add_byte(8'h00, 1'b1, 1'b0, 16'h0000);
                    add_byte(regs.win_y_start, 1'b1, 1'b0, 16'h0000);
                    add_byte(8'h00, 1'b1, 1'b0, 16'h0000);
                    add_byte(regs.win_y_end, 1'b1, 1'b0, 16'h0000);
                    add_byte(ckc_pkg::OP_MEMWR, 1'b0, 1'b1, 16'h0000);
                    cursor_col = regs.win_x_start;
                    cursor_row = regs.win_y_start;
                end
                ckc_pkg::CMD_PIXEL:
                begin
                    res = pix;
                    if (pix == regs.key_color)
                        res = on_screen ? bg_store[idx] : 16'h0000;
                    if (regs.write_back && on_screen)
                        store_pixel(idx, res);
                    add_byte(res[15:8], 1'b1, 1'b0, 16'h0000);
                    add_byte(res[7:0], 1'b1, 1'b1, 16'h0000);
                    // Raster advance inside the window; both counters wrap at
                    // their natural width, so inverted windows run through 0.
                    if (cursor_col == regs.win_x_end)
                    begin
                        cursor_col = regs.win_x_start;
                        if (cursor_row == regs.win_y_end)
                            cursor_row = regs.win_y_start;
                        else
                            cursor_row = cursor_row + 8'd1;
                    end
                    else
                    begin
                        cursor_col = cursor_col + 7'd1;
                    end
                end
                ckc_pkg::CMD_READ:
                begin
                    add_byte(8'h00, 1'b0, 1'b1,
                             (addr < SCREEN_PIXELS) ? bg_store[addr] : 16'h0000);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %04h, wanted %04h", name, got, want));
        endtask

        task match_byte(link_byte_t got);
            link_byte_t want;
            if (pending_link_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h is_data %0b last %0b read %04h",
                                          got.out_byte, got.is_data, got.last,
                                          got.read_value));
            end
            else
            begin
                want = pending_link_bytes.pop_front();
                compare_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
                compare_field("is_data", 16'(got.is_data), 16'(want.is_data));
                compare_field("last", 16'(got.last), 16'(want.last));
                compare_field("read_value", got.read_value, want.read_value);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                            cfg_we;
    logic [ckc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ckc_pkg::CFG_DATA_W-1:0]  cfg_data;

    ckc_cmd_if  cmd_ch ();
    ckc_link_if link_ch ();

    compositor_mirror mirror = new();

    // Set by the main process: both sides stop idling while this is high.
    bit steady = 1'b0;
    // Set by the main process; the receiver then stalls for a long stretch.
    bit hold_off_req = 1'b0;

    color_key_sprite_compositor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .link_ch   (link_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one command item and returns at the edge where it is taken. The
    // valid is left high on return: the next call either lowers it for a gap
    // or puts the next item on the bus in the same time step.
    task automatic send_item(ckc_pkg::cmd_t c, logic [14:0] addr, logic [15:0] pix);
        while (!steady && ($urandom_range(99) < IDLE_PCT))
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= c;
        cmd_ch.address     <= addr;
        cmd_ch.pixel_value <= pix;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        mirror.take_item(c, addr, pix);
    endtask

    // A keyed pixel reads the background at the cursor. When that entry has
    // never been loaded, a load of it goes first so that no garbage is read.
    task automatic send_pixel(logic [15:0] pix);
        if (mirror.needs_background(pix))
            send_item(ckc_pkg::CMD_LOAD, 15'(mirror.cursor_index()), 16'($urandom));
        send_item(ckc_pkg::CMD_PIXEL, 15'($urandom), pix);
    endtask

    // Drops the valid, waits for every pending byte, then lets the pipeline
    // run dry, since a load leaves nothing behind to wait for.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (mirror.pending_link_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // The enable is left high between back-to-back writes; the caller lowers it.
    task automatic write_register(ckc_pkg::cfg_index_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        mirror.set_register(idx, value);
    endtask

    task automatic apply_settings(logic [6:0] xs, logic [6:0] xe, logic [7:0] ys,
                                  logic [7:0] ye, logic [15:0] key, logic wb);
        wait_idle();
        write_register(ckc_pkg::CFG_X_START, 16'(xs));
        write_register(ckc_pkg::CFG_X_END, 16'(xe));
        write_register(ckc_pkg::CFG_Y_START, 16'(ys));
        write_register(ckc_pkg::CFG_Y_END, 16'(ye));
        write_register(ckc_pkg::CFG_KEY_COLOR, key);
        write_register(ckc_pkg::CFG_WRITE_BACK, 16'(wb));
        cfg_we <= 1'b0;
    endtask

    // Mostly sprite pixels, so the cursor travels far through the window; the
    // rest are loads, begins (which restart the window) and reads. Reads
    // target entries that hold data, or addresses beyond the screen.
    task automatic send_random_items(int unsigned count, int unsigned pixel_pct,
                                     int unsigned begin_pct);
        int unsigned roll;
        logic [14:0] addr;
        logic [15:0] pix;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < pixel_pct)
            begin
                pix = ($urandom_range(99) < 35) ? mirror.regs.key_color : 16'($urandom);
                send_pixel(pix);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < begin_pct)
                begin
                    send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
                end
                else if (roll < begin_pct + (100 - begin_pct) / 2)
                begin
                    if ($urandom_range(99) < 80)
                        addr = 15'($urandom_range(SCREEN_PIXELS - 1));
                    else
                        addr = 15'($urandom_range(ADDRESS_SPAN - 1, SCREEN_PIXELS));
                    send_item(ckc_pkg::CMD_LOAD, addr, 16'($urandom));
                end
                else
                begin
                    if ((mirror.written_addr.size() == 0) || ($urandom_range(99) < 15))
                        addr = 15'($urandom_range(ADDRESS_SPAN - 1, SCREEN_PIXELS));
                    else
                        addr = 15'(mirror.written_addr[
                                   $urandom_range(mirror.written_addr.size() - 1)]);
                    send_item(ckc_pkg::CMD_READ, addr, 16'($urandom));
                end
            end
        end
    endtask

    // Receiver: checks each accepted byte and then decides the ready for the
    // next cycle. The long hold-off is counted here, in its own process, so
    // the sender keeps offering items while the block backs up.
    initial
    begin : link_receiver
        int unsigned hold_left;
        link_byte_t  got;
        hold_left = 0;
        link_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (link_ch.valid && link_ch.ready)
            begin
                got.out_byte   = link_ch.out_byte;
                got.is_data    = link_ch.is_data;
                got.last       = link_ch.last;
                got.read_value = link_ch.read_value;
                mirror.match_byte(got);
            end
            if ((hold_left == 0) && hold_off_req)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                link_ch.ready <= 1'b0;
            end
            else if (steady)
            begin
                link_ch.ready <= 1'b1;
            end
            else
            begin
                link_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count. A stuck
    // block, a lost byte or a missing expected byte all end up here.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (link_ch.valid && link_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL color_key_sprite_compositor");
        $finish;
    end

    initial
    begin : stimulus
        logic [6:0]  xs;
        logic [6:0]  xe;
        logic [7:0]  ys;
        logic [7:0]  ye;
        int unsigned span;

        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd         <= ckc_pkg::CMD_LOAD;
        cmd_ch.address     <= 15'd0;
        cmd_ch.pixel_value <= 16'h0000;
        cfg_we             <= 1'b0;
        cfg_index          <= ckc_pkg::CFG_X_START;
        cfg_data           <= 16'h0000;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first at the reset values of the registers. A sprite
        // pixel before any begin uses the cursor at the origin.
        send_pixel(16'h1234);
        send_item(ckc_pkg::CMD_LOAD, 15'd0, 16'hFFFF);
        send_item(ckc_pkg::CMD_LOAD, 15'(SCREEN_PIXELS - 1), 16'h0001);
        // Loads beyond the screen are dropped and reads there give zero.
        send_item(ckc_pkg::CMD_LOAD, 15'(SCREEN_PIXELS), 16'hABCD);
        send_item(ckc_pkg::CMD_LOAD, 15'(ADDRESS_SPAN - 1), 16'h5555);
        send_item(ckc_pkg::CMD_READ, 15'd0, 16'h0000);
        send_item(ckc_pkg::CMD_READ, 15'(SCREEN_PIXELS - 1), 16'hFFFF);
        send_item(ckc_pkg::CMD_READ, 15'(SCREEN_PIXELS), 16'h0000);
        send_item(ckc_pkg::CMD_READ, 15'(ADDRESS_SPAN - 1), 16'hFFFF);
        send_item(ckc_pkg::CMD_BEGIN, 15'(ADDRESS_SPAN - 1), 16'hFFFF);
        // Key color zero at the origin pulls in the loaded 0xFFFF.
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8001);

        // A one-pixel window in the last corner, with write-back, so that the
        // cursor never moves and each composite lands on the same entry.
        apply_settings(7'd127, 7'd127, 8'd159, 8'd159, 16'hFFFF, 1'b1);
        send_item(ckc_pkg::CMD_BEGIN, 15'd0, 16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5A5A);
        send_item(ckc_pkg::CMD_READ, 15'(SCREEN_PIXELS - 1), 16'h0000);

        // Both window edges inverted: the column runs through 127 to 0, and
        // the row steps past the last screen row, where keyed pixels give 0.
        apply_settings(7'd126, 7'd1, 8'd159, 8'd0, 16'h0000, 1'b0);
        send_item(ckc_pkg::CMD_BEGIN, 15'd0, 16'h0000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hC3C3);

        // Full screen at the default window, random key color.
        apply_settings(7'd0, 7'd127, 8'd0, 8'd159, 16'($urandom), 1'b0);
        send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        send_random_items(25, 70, 20);

        // A small window with write-back, so rows turn over often.
        xs   = 7'($urandom_range(127));
        span = $urandom_range(7);
        xe   = (int'(xs) + span > 127) ? 7'd127 : 7'(int'(xs) + span);
        ys   = 8'($urandom_range(159));
        span = $urandom_range(4);
        ye   = (int'(ys) + span > 159) ? 8'd159 : 8'(int'(ys) + span);
        apply_settings(xs, xe, ys, ye, 16'($urandom), 1'b1);
        send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        send_random_items(25, 70, 20);

        // Registers rewritten in the middle of the window: no begin, so the
        // cursor stays where it was. Neither side idles in this phase.
        apply_settings(xs, xe, ys, ye, 16'hFFFF, 1'b0);
        steady = 1'b1;
        send_random_items(40, 70, 20);
        steady = 1'b0;

        // Long receiver stall while items keep coming: the block must fill
        // up and hold its input off without losing anything.
        xs = 7'($urandom_range(127));
        xe = 7'($urandom_range(127, int'(xs)));
        ys = 8'($urandom_range(159));
        ye = 8'($urandom_range(159, int'(ys)));
        apply_settings(xs, xe, ys, ye, 16'h0000, 1'b1);
        send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        hold_off_req = 1'b1;
        send_random_items(25, 80, 20);

        // One column from the bottom row to a top row: the row counter
        // walks through the rows beyond the screen and wraps to zero.
        xs = 7'($urandom_range(127));
        apply_settings(xs, xs, 8'd159, 8'($urandom_range(3)), 16'($urandom),
                       1'($urandom_range(1)));
        send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        send_random_items(130, 92, 0);

        // Column range inverted across the right edge.
        ys = 8'($urandom_range(159));
        span = $urandom_range(3);
        ye = (int'(ys) + span > 159) ? 8'd159 : 8'(int'(ys) + span);
        apply_settings(7'($urandom_range(127, 120)), 7'($urandom_range(7)), ys, ye,
                       16'($urandom), 1'b1);
        send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        send_random_items(25, 70, 20);

        // Anything goes: any window, any key, with or without a begin first.
        apply_settings(7'($urandom_range(127)), 7'($urandom_range(127)),
                       8'($urandom_range(159)), 8'($urandom_range(159)),
                       16'($urandom), 1'($urandom_range(1)));
        if ($urandom_range(1) == 1)
            send_item(ckc_pkg::CMD_BEGIN, 15'($urandom), 16'($urandom));
        send_random_items(25, 60, 20);

        // Drain: every expected byte must arrive, and nothing may follow.
        wait_idle();
        if (mirror.mismatch_count == 0)
            $display("PASS color_key_sprite_compositor");
        else
            $display("FAIL color_key_sprite_compositor");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/ckc_pkg.sv
sv/ckc_if.sv
sv/ckc_front.sv
sv/ckc_queue.sv
sv/ckc_back.sv
sv/ckc_emit.sv
sv/color_key_sprite_compositor.sv
verif/tb.sv
